// ===== sv/fsk_square_wave_byte_modulator_unit_assert.svh =====
// Assertion macros shared by the FSK modulator RTL.
`ifndef FSK_SQUARE_WAVE_BYTE_MODULATOR_UNIT_ASSERT_SVH
`define FSK_SQUARE_WAVE_BYTE_MODULATOR_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define FSK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define FSK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/fskmod_pkg.sv =====
// Types and constants of the FSK byte modulator.
package fskmod_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_START = 2'd1,
      KIND_OFF   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MARK_TICKS   = 2'd0,
      CSR_MARK_HALVES  = 2'd1,
      CSR_SPACE_TICKS  = 2'd2,
      CSR_SPACE_HALVES = 2'd3
   } csr_index_type;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned TICKS_WIDTH  = 16;
   localparam int unsigned HALVES_WIDTH = 8;
   localparam int unsigned RSP_WIDTH    = 8;

   localparam logic [TICKS_WIDTH-1:0]  MARK_TICKS_RESET   = 16'd333;
   localparam logic [HALVES_WIDTH-1:0] MARK_HALVES_RESET  = 8'd5;
   localparam logic [TICKS_WIDTH-1:0]  SPACE_TICKS_RESET  = 16'd556;
   localparam logic [HALVES_WIDTH-1:0] SPACE_HALVES_RESET = 8'd3;

endpackage

// ===== sv/fsk_square_wave_byte_modulator_unit.sv =====
// Square-wave FSK byte modulator: framing, tone timing and result register.
//
// Usage:
//   req_ channel carries one word per clock tick of the output waveform.
//   req_tuser selects the kind: tick, start a frame with req_tdata, or force
//   the line low. Start and force are taken only while no frame is being sent;
//   otherwise the result reports accepted = 0 and nothing changes.
//   A frame is mark, mark, space start bit, DATA_BITS data bits LSB first and
//   a mark stop bit; each bit is several half periods of its tone, and the
//   line toggles at the start of each half period.
//   rsp_ channel returns exactly one word per request word: line level, busy,
//   accepted and frame done, registered and valid in the cycle after acceptance.
//   Throughput is one word per cycle while results are taken; all work for a word
//   is one pass of logic between the state registers and the result register.
//   If rsp_tready is low the result word holds and req_tready drops until the
//   result is taken, so nothing is lost.
//   csr_ channel writes the tone registers at any time (csr_ready is always
//   high); write them only while idle.
//   Reset (synchronous, active high) clears the frame state, drops the line,
//   empties the result register and restores the tone register defaults.
`include "fsk_square_wave_byte_modulator_unit_assert.svh"

module fsk_square_wave_byte_modulator_unit #(
   parameter int unsigned DATA_BITS        = 8,
   parameter int unsigned TICK_COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] line_level, [1] busy_res, [2] accepted,
                                    // [3] frame_done, [7:4] zero
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned FRAME_BITS = DATA_BITS + 4;
   localparam int unsigned IDX_W      = $clog2(FRAME_BITS);
   localparam int unsigned TW         = TICK_COUNT_WIDTH;
   localparam int unsigned CW         = (TW > fskmod_pkg::TICKS_WIDTH) ?
                                        TW : fskmod_pkg::TICKS_WIDTH;
   localparam int unsigned HW         = fskmod_pkg::HALVES_WIDTH;
   localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(FRAME_BITS - 1);

   // tone registers
   logic [fskmod_pkg::TICKS_WIDTH-1:0] mark_ticks_ff, space_ticks_ff;
   logic [HW-1:0]                      mark_halves_ff, space_halves_ff;

   // frame state
   logic                  phase_ff, phase_in;
   logic                  line_ff, line_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [IDX_W-1:0]      bit_index_ff, bit_index_in;
   logic [HW-1:0]         halves_ff, halves_in;
   logic [TW-1:0]         ticks_ff, ticks_in;
   logic                  sending_ff, sending_in;

   // result register
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_data_ff;

   logic                  req_fire;
   logic                  accepted;
   logic                  done;
   logic [FRAME_BITS-1:0] frame_word;
   logic                  cur_bit;
   logic [CW-1:0]         half_raw;
   logic [TW-1:0]         half_ticks;
   logic [HW-1:0]         halves_raw;
   logic [HW:0]           halves_need;
   logic [TW-1:0]         ticks_cur;
   fskmod_pkg::kind_type  kind;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign kind       = fskmod_pkg::kind_type'(req_tuser);

   // build frame: bits 0 and 1 mark, bit 2 start, data, stop on top
   always_comb begin
      frame_word    = '0;
      frame_word[0] = 1'b1;
      frame_word[1] = 1'b1;
      for (int i = 0; i < DATA_BITS; i++) begin
         frame_word[i + 3] = (i < fskmod_pkg::BYTE_WIDTH) ?
                             req_tdata[i % fskmod_pkg::BYTE_WIDTH] : 1'b0;
      end
      frame_word[FRAME_BITS-1] = 1'b1;
   end

   // tone timing of the bit on the line; zero counts act as one, wide counts saturate
   always_comb begin
      cur_bit  = frame_ff[bit_index_ff];
      half_raw = cur_bit ? CW'(mark_ticks_ff) : CW'(space_ticks_ff);
      if (half_raw == '0) begin
         half_raw = CW'(1);
      end
      if (half_raw > CW'({TW{1'b1}})) begin
         half_raw = CW'({TW{1'b1}});
      end
      half_ticks = half_raw[TW-1:0];
      halves_raw = cur_bit ? mark_halves_ff : space_halves_ff;
      if (halves_raw == '0) begin
         halves_raw = HW'(1);
      end
      halves_need = {1'b0, halves_raw};
   end

   always_comb begin
      phase_in     = phase_ff;
      line_in      = line_ff;
      frame_in     = frame_ff;
      bit_index_in = bit_index_ff;
      halves_in    = halves_ff;
      ticks_in     = ticks_ff;
      sending_in   = sending_ff;
      accepted     = 1'b0;
      done         = 1'b0;
      ticks_cur    = ticks_ff;
      if (req_fire) begin
         unique case (kind)
            fskmod_pkg::KIND_START: begin
               if (!sending_ff) begin
                  frame_in     = frame_word;
                  bit_index_in = '0;
                  halves_in    = '0;
                  ticks_in     = '0;
                  sending_in   = 1'b1;
                  accepted     = 1'b1;
               end
            end
            fskmod_pkg::KIND_OFF: begin
               if (!sending_ff) begin
                  line_in  = 1'b0;
                  accepted = 1'b1;
               end
            end
            fskmod_pkg::KIND_TICK: begin
               if (sending_ff) begin
                  // new half period: toggle and reload the tick count
                  if (ticks_ff == '0) begin
                     phase_in  = ~phase_ff;
                     line_in   = ~phase_ff;
                     ticks_cur = half_ticks;
                  end
                  ticks_cur = ticks_cur - TW'(1);
                  ticks_in  = ticks_cur;
                  if (ticks_cur == '0) begin
                     if (({1'b0, halves_ff} + (HW+1)'(1)) >= halves_need) begin
                        halves_in = '0;
                        if (bit_index_ff == LAST_BIT) begin
                           bit_index_in = '0;
                           sending_in   = 1'b0;
                           done         = 1'b1;
                        end else begin
                           bit_index_in = bit_index_ff + IDX_W'(1);
                        end
                     end else begin
                        halves_in = halves_ff + HW'(1);
                     end
                  end
               end
            end
            default: begin
               // unused kind: no time passes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ticks_ff   <= fskmod_pkg::MARK_TICKS_RESET;
         mark_halves_ff  <= fskmod_pkg::MARK_HALVES_RESET;
         space_ticks_ff  <= fskmod_pkg::SPACE_TICKS_RESET;
         space_halves_ff <= fskmod_pkg::SPACE_HALVES_RESET;
         phase_ff        <= 1'b0;
         line_ff         <= 1'b0;
         frame_ff        <= '0;
         bit_index_ff    <= '0;
         halves_ff       <= '0;
         ticks_ff        <= '0;
         sending_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (fskmod_pkg::csr_index_type'(csr_index))
               fskmod_pkg::CSR_MARK_TICKS:   mark_ticks_ff   <= csr_data;
               fskmod_pkg::CSR_MARK_HALVES:  mark_halves_ff  <= csr_data[HW-1:0];
               fskmod_pkg::CSR_SPACE_TICKS:  space_ticks_ff  <= csr_data;
               fskmod_pkg::CSR_SPACE_HALVES: space_halves_ff <= csr_data[HW-1:0];
               default: ;
            endcase
         end
         phase_ff     <= phase_in;
         line_ff      <= line_in;
         frame_ff     <= frame_in;
         bit_index_ff <= bit_index_in;
         halves_ff    <= halves_in;
         ticks_ff     <= ticks_in;
         sending_ff   <= sending_in;
         // load on accept, drop once taken
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {4'b0000, done, accepted, sending_in, line_in};
      end
   end

   `FSK_ASSERT_NOW(a_idle_counters_clear, !sending_ff,
      (ticks_ff == '0) && (halves_ff == '0) && (bit_index_ff == '0),
      "frame counters not clear while idle")
   `FSK_ASSERT_NOW(a_bit_index_range, sending_ff,
      bit_index_ff <= LAST_BIT,
      "bit index beyond frame")
   `FSK_ASSERT_NOW(a_done_not_busy, rsp_valid_ff && rsp_data_ff[3],
      !rsp_data_ff[1] && !sending_ff,
      "frame done reported while still busy")
   `FSK_ASSERT_NEXT(a_start_takes, req_fire && (kind == fskmod_pkg::KIND_START) && !sending_ff,
      sending_ff && rsp_data_ff[2],
      "idle start word not taken")

endmodule
